>>> sv/stsg_pkg.sv
// stsg_pkg: shared constants and register codes of the sine tone sample generator
// no dependencies; used by every module of the block
`default_nettype none

package stsg_pkg;

  // default parameter values
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  // fixed field widths
  localparam int INDEX_W   = 48;
  localparam int STEP_W    = 32;
  localparam int AMP_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // register reset values and limits
  localparam logic [STEP_W-1:0] STEP_RESET = 32'd89478485;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd3277;
  localparam logic [AMP_W-1:0]  AMP_FULL   = 16'd32768;

  // quarter-wave table generation, Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 1'b0,
    REG_AMPLITUDE  = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

>>> sv/stsg_phase.sv
// stsg_phase: two-stage phase pipeline, index times phase step, low bits kept
// depends on stsg_pkg
`default_nettype none

module stsg_phase #(
  parameter int PHASE_BITS = stsg_pkg::PHASE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [stsg_pkg::INDEX_W-1:0] up_index,
  input  wire logic [stsg_pkg::STEP_W-1:0]  step,
  output logic                              dn_valid,
  input  wire logic                         dn_ready,
  output logic [PHASE_BITS-1:0]             dn_phase
);

  localparam int LO_W = 32;
  localparam int HI_W = stsg_pkg::INDEX_W - LO_W;

  logic                        v1_r, v2_r;
  logic                        en1, en2;
  logic [LO_W+stsg_pkg::STEP_W-1:0] lo_prod_r;
  logic [HI_W+stsg_pkg::STEP_W-1:0] hi_prod_r;
  logic [63:0]                 sum;
  logic [PHASE_BITS-1:0]       phase_r;

  // stage enables, a stage moves when empty or when the next one moves
  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  // stage 1: partial products of the 48 x 32 multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      lo_prod_r <= (LO_W+stsg_pkg::STEP_W)'(up_index[LO_W-1:0]) *
                   (LO_W+stsg_pkg::STEP_W)'(step);
      hi_prod_r <= (HI_W+stsg_pkg::STEP_W)'(up_index[stsg_pkg::INDEX_W-1:LO_W]) *
                   (HI_W+stsg_pkg::STEP_W)'(step);
    end
  end

  // stage 2: combine partial products, wrap to phase width
  assign sum = lo_prod_r + {hi_prod_r[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      phase_r <= sum[PHASE_BITS-1:0];
    end
  end

  assign dn_valid = v2_r;
  assign dn_phase = phase_r;

endmodule

`default_nettype wire

>>> sv/stsg_rom.sv
// stsg_rom: quadrant decode and registered quarter-wave sine table read
// depends on stsg_pkg
`default_nettype none

module stsg_rom #(
  parameter int PHASE_BITS      = stsg_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = stsg_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = stsg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   up_valid,
  output logic                        up_ready,
  input  wire logic [PHASE_BITS-1:0]  up_phase,
  output logic                        dn_valid,
  input  wire logic                   dn_ready,
  output logic [SAMPLE_BITS-1:0]      dn_entry,
  output logic                        dn_peak,
  output logic                        dn_neg
);

  localparam int TBL = 1 << SINE_TABLE_BITS;
  localparam logic [7:0] SINE_DIV [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

  typedef logic [SAMPLE_BITS-1:0] rom_t [TBL];

  // table of round(sin(pi/2 * k / TBL) * 2^(SAMPLE_BITS-1)), Taylor series in Q30
  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] s;
    for (int k = 0; k < TBL; k++) begin
      a    = (stsg_pkg::HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      a2   = (a * a) >> 30;
      term = a;
      sum  = a;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * a2) >> 30) / 64'(SINE_DIV[n-1]);
        if (n[0]) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > stsg_pkg::Q30_ONE) begin
        sum = stsg_pkg::Q30_ONE;
      end
      s      = (sum << (SAMPLE_BITS - 1)) + (64'd1 << 29);
      tbl[k] = SAMPLE_BITS'(s >> 30);
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [SINE_TABLE_BITS-1:0] addr;
  logic                       v_r, en;
  logic [SAMPLE_BITS-1:0]     entry_r;
  logic                       peak_r, neg_r;

  // quadrant and table offset, odd quadrants read mirrored
  assign quad = up_phase[PHASE_BITS-1 -: 2];
  assign k    = up_phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign addr = quad[0] ? (SINE_TABLE_BITS'(0) - k) : k;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  // registered table read; mirror landing on the right angle uses full scale
  always_ff @(posedge clk) begin
    if (en) begin
      entry_r <= SINE_ROM[addr];
      peak_r  <= quad[0] && (k == '0);
      neg_r   <= quad[1];
    end
  end

  assign dn_valid = v_r;
  assign dn_entry = entry_r;
  assign dn_peak  = peak_r;
  assign dn_neg   = neg_r;

endmodule

`default_nettype wire

>>> sv/stsg_scale.sv
// stsg_scale: amplitude multiply, rounding, saturation and sign restore
// depends on stsg_pkg
`default_nettype none

module stsg_scale #(
  parameter int SAMPLE_BITS = stsg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [SAMPLE_BITS-1:0]      up_entry,
  input  wire logic                        up_peak,
  input  wire logic                        up_neg,
  input  wire logic [stsg_pkg::AMP_W-1:0]  amp,
  input  wire logic                        silent,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output logic signed [SAMPLE_BITS-1:0]    dn_sample
);

  localparam int PW = SAMPLE_BITS + stsg_pkg::AMP_W;
  localparam logic [SAMPLE_BITS-1:0] PEAK    = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS:0]   MAG_MAX = (SAMPLE_BITS+1)'(PEAK) - 1'b1;

  logic                   v4_r, v5_r;
  logic                   en4, en5;
  logic [SAMPLE_BITS-1:0] entry;
  logic [PW-1:0]          prod_r;
  logic                   neg4_r;
  logic [PW-1:0]          rnd;
  logic [SAMPLE_BITS:0]   mag;
  logic [SAMPLE_BITS-1:0] mag_sat;
  logic [SAMPLE_BITS-1:0] sample_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;

  assign en5      = !v5_r || dn_ready;
  assign en4      = !v4_r || en5;
  assign up_ready = en4;

  // stage 4: entry times Q1.15 amplitude
  assign entry = up_peak ? PEAK : up_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      prod_r <= PW'(entry) * PW'(amp);
      neg4_r <= up_neg;
    end
  end

  // stage 5: round, saturate symmetric, negate for the lower half, zero when silent
  always_comb begin
    rnd        = prod_r + PW'(1 << 14);
    mag        = rnd[PW-1:15];
    mag_sat    = (mag > MAG_MAX) ? MAG_MAX[SAMPLE_BITS-1:0] : mag[SAMPLE_BITS-1:0];
    sample_nxt = neg4_r ? (SAMPLE_BITS'(0) - mag_sat) : mag_sat;
    if (silent) begin
      sample_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      sample_r <= sample_nxt;
    end
  end

  assign dn_valid  = v5_r;
  assign dn_sample = sample_r;

endmodule

`default_nettype wire

>>> sv/sine_tone_sample_generator_unit.sv
// sine_tone_sample_generator_unit: top level, configuration registers and pipeline
// depends on stsg_pkg, stsg_phase, stsg_rom, stsg_scale
`default_nettype none

// Direct digital synthesis sine generator. Each input word carries an absolute
// sample index; the block returns amplitude * sin(2*pi*index*phase_step/2^PHASE_BITS)
// as a signed SAMPLE_BITS sample. It takes one word per cycle unless the output
// stalls the pipeline; each word passes five register stages on its way to the
// output register: two stages for the 48 x 32 phase multiply (partial products, then
// sum), one for the quarter-wave table read, one for the amplitude multiply and one
// for rounding and saturation. Stages move independently, so empty stages fill while
// a result waits at the output.
// A phase_step at or above half of the phase range gives silence; amplitude
// writes above 32768 are held at full scale. Write configuration only while idle.
module sine_tone_sample_generator_unit #(
  parameter int PHASE_BITS      = stsg_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = stsg_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = stsg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [stsg_pkg::INDEX_W-1:0]   in_sample_index,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_value,
  input  wire logic                           cfg_we,
  input  wire logic [stsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [stsg_pkg::CFG_W-1:0]     cfg_wdata
);

  logic [stsg_pkg::STEP_W-1:0] step_r;
  logic [stsg_pkg::AMP_W-1:0]  amp_r;
  logic [stsg_pkg::AMP_W-1:0]  amp_nxt;
  logic                        silent_r;

  logic                        ph_valid, ph_ready;
  logic [PHASE_BITS-1:0]       ph_phase;
  logic                        rom_valid, rom_ready;
  logic [SAMPLE_BITS-1:0]      rom_entry;
  logic                        rom_peak, rom_neg;

  // amplitude saturates to full scale on write
  assign amp_nxt = (cfg_wdata[stsg_pkg::AMP_W-1:0] > stsg_pkg::AMP_FULL) ?
                   stsg_pkg::AMP_FULL : cfg_wdata[stsg_pkg::AMP_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= stsg_pkg::STEP_RESET;
      amp_r  <= stsg_pkg::AMP_RESET;
    end else if (cfg_we) begin
      unique case (stsg_pkg::cfg_idx_t'(cfg_index))
        stsg_pkg::REG_PHASE_STEP: step_r <= cfg_wdata[stsg_pkg::STEP_W-1:0];
        stsg_pkg::REG_AMPLITUDE:  amp_r  <= amp_nxt;
        default: ;
      endcase
    end
  end

  // frequency at or above half the sample rate silences the output
  always_ff @(posedge clk) begin
    silent_r <= {32'd0, step_r} >= (64'd1 << (PHASE_BITS - 1));
  end

  stsg_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_index (in_sample_index),
    .step     (step_r),
    .dn_valid (ph_valid),
    .dn_ready (ph_ready),
    .dn_phase (ph_phase)
  );

  stsg_rom #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_rom (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ph_valid),
    .up_ready (ph_ready),
    .up_phase (ph_phase),
    .dn_valid (rom_valid),
    .dn_ready (rom_ready),
    .dn_entry (rom_entry),
    .dn_peak  (rom_peak),
    .dn_neg   (rom_neg)
  );

  stsg_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (rom_valid),
    .up_ready  (rom_ready),
    .up_entry  (rom_entry),
    .up_peak   (rom_peak),
    .up_neg    (rom_neg),
    .amp       (amp_r),
    .silent    (silent_r),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .dn_sample (out_sample_value)
  );

  // free output means every stage can move, so the input is open
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output drains");

  // saturation is symmetric, the most negative code never appears
  a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_value != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
    else $error("sample reached the most negative code");

  // amplitude register never exceeds full scale
  a_amp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    amp_r <= stsg_pkg::AMP_FULL)
    else $error("amplitude above full scale");

  // oversized amplitude write lands at full scale
  a_amp_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == stsg_pkg::REG_AMPLITUDE) &&
     (cfg_wdata[stsg_pkg::AMP_W-1:0] > stsg_pkg::AMP_FULL)) |=> (amp_r == stsg_pkg::AMP_FULL))
    else $error("amplitude write not saturated");

endmodule

`default_nettype wire
